// ===== rtl/rau_pkg.sv =====
// rational arithmetic unit: shared types and constants
// no dependencies
package rau_pkg;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  // datapath commands from the controller
  typedef struct packed {
    logic load;      // capture operands
    logic prod;      // start one product step (index in prod_sel)
    logic [1:0] prod_sel;
    logic combine;   // form numerator and denominator
    logic gcd_step;  // one binary gcd step
    logic div_start; // start reducing divisions
    logic div_step;  // one restoring division bit for both values
    logic finish;    // range check and write result register
  } rau_cmd_t;

  // datapath status to the controller
  typedef struct packed {
    logic bad_den;
    logic div_zero;
    logic num_zero;
    logic gcd_done;
    logic div_done;
  } rau_stat_t;

endpackage

// ===== rtl/rau_datapath.sv =====
// rational arithmetic unit datapath: products, binary gcd, serial dividers
// depends on rau_pkg
module rau_datapath #(
  parameter int WORD_BITS = 32
) (
  input  logic                clk_i,
  input  logic [1:0]          req_type_i,
  input  logic signed [31:0]  a_num_i,
  input  logic [30:0]         a_den_i,
  input  logic signed [31:0]  b_num_i,
  input  logic [30:0]         b_den_i,
  input  rau_pkg::rau_cmd_t   cmd_i,
  output rau_pkg::rau_stat_t  stat_o,
  output logic signed [31:0]  res_num_o,
  output logic [30:0]         res_den_o,
  output logic [1:0]          status_o
);
  import rau_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int DW = 2 * W;
  localparam int CW = $clog2(DW + 1);

  logic [1:0]         op_q;
  logic signed [W-1:0] an_q, bn_q;
  logic [W-2:0]       ad_q, bd_q;
  logic signed [DW-1:0] p_q [4];
  logic [DW-1:0]      nm_q, dm_q, x_q, y_q, qn_q, qd_q, rn_q, rd_q, g_q;
  logic               neg_q;
  logic [CW-1:0]      sh_q, cnt_q;
  logic signed [31:0] rnum_q;
  logic [30:0]        rden_q;
  logic [1:0]         rst_q;

  // operand selection for the product unit, one product per step
  logic signed [W-1:0] m_a, m_b;
  always_comb begin
    case (cmd_i.prod_sel)
      2'd0:    begin m_a = an_q; m_b = signed'({1'b0, bd_q}); end
      2'd1:    begin m_a = bn_q; m_b = signed'({1'b0, ad_q}); end
      2'd2:    begin m_a = an_q; m_b = bn_q; end
      default: begin m_a = signed'({1'b0, ad_q}); m_b = signed'({1'b0, bd_q}); end
    endcase
  end

  // combine products into numerator and denominator
  logic signed [DW-1:0] num_c, den_c;
  always_comb begin
    case (op_q)
      OP_ADD:  begin num_c = p_q[0] + p_q[1]; den_c = p_q[3]; end
      OP_SUB:  begin num_c = p_q[0] - p_q[1]; den_c = p_q[3]; end
      OP_MUL:  begin num_c = p_q[2]; den_c = p_q[3]; end
      default: begin num_c = p_q[0]; den_c = p_q[1]; end
    endcase
  end

  // binary gcd step
  logic [DW-1:0] gx_d, gy_d, dif;
  logic [CW-1:0] sh_d;
  always_comb begin
    gx_d = x_q; gy_d = y_q; sh_d = sh_q;
    dif = (x_q > y_q) ? x_q - y_q : y_q - x_q;
    if (!x_q[0] && !y_q[0]) begin
      gx_d = x_q >> 1; gy_d = y_q >> 1; sh_d = sh_q + 1'b1;
    end else if (!x_q[0]) begin
      gx_d = x_q >> 1;
    end else if (!y_q[0]) begin
      gy_d = y_q >> 1;
    end else if (x_q > y_q) begin
      gx_d = dif >> 1;
    end else begin
      gy_d = dif >> 1;
    end
  end

  // restoring division bits for both reductions
  logic [DW:0] tn, td;
  assign tn = {rn_q, qn_q[DW-1]} - {1'b0, g_q};
  assign td = {rd_q, qd_q[DW-1]} - {1'b0, g_q};

  // range check
  logic [DW-1:0] lim;
  logic          ovf;
  assign lim = DW'(1) << (W - 1);
  assign ovf = (qd_q > lim - 1'b1) || (qn_q > (neg_q ? lim : lim - 1'b1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= req_type_i;
      an_q <= a_num_i[W-1:0];
      bn_q <= b_num_i[W-1:0];
      ad_q <= a_den_i[W-2:0];
      bd_q <= b_den_i[W-2:0];
    end
    if (cmd_i.prod) p_q[cmd_i.prod_sel] <= DW'(m_a) * DW'(m_b);
    if (cmd_i.combine) begin
      neg_q <= num_c[DW-1] ^ den_c[DW-1];
      nm_q  <= num_c[DW-1] ? DW'(-num_c) : DW'(num_c);
      dm_q  <= den_c[DW-1] ? DW'(-den_c) : DW'(den_c);
      x_q   <= num_c[DW-1] ? DW'(-num_c) : DW'(num_c);
      y_q   <= den_c[DW-1] ? DW'(-den_c) : DW'(den_c);
      sh_q  <= '0;
    end
    if (cmd_i.gcd_step) begin
      x_q <= gx_d; y_q <= gy_d; sh_q <= sh_d;
    end
    if (cmd_i.div_start) begin
      g_q   <= (x_q | y_q) << sh_q;
      qn_q  <= nm_q; qd_q <= dm_q;
      rn_q  <= '0;   rd_q <= '0;
      cnt_q <= CW'(DW);
    end
    if (cmd_i.div_step) begin
      cnt_q <= cnt_q - 1'b1;
      if (!tn[DW]) begin
        rn_q <= tn[DW-1:0]; qn_q <= {qn_q[DW-2:0], 1'b1};
      end else begin
        rn_q <= {rn_q[DW-2:0], qn_q[DW-1]}; qn_q <= {qn_q[DW-2:0], 1'b0};
      end
      if (!td[DW]) begin
        rd_q <= td[DW-1:0]; qd_q <= {qd_q[DW-2:0], 1'b1};
      end else begin
        rd_q <= {rd_q[DW-2:0], qd_q[DW-1]}; qd_q <= {qd_q[DW-2:0], 1'b0};
      end
    end
    if (cmd_i.finish) begin
      if (stat_o.bad_den || stat_o.div_zero) begin
        rnum_q <= '0; rden_q <= 31'd1; rst_q <= ST_DIV0;
      end else if (stat_o.num_zero) begin
        rnum_q <= '0; rden_q <= 31'd1; rst_q <= ST_OK;
      end else if (ovf) begin
        rnum_q <= '0; rden_q <= 31'd1; rst_q <= ST_OVF;
      end else begin
        rnum_q <= 32'(signed'(neg_q ? W'(-qn_q[W-1:0]) : qn_q[W-1:0]));
        rden_q <= 31'(qd_q[W-2:0]);
        rst_q  <= ST_OK;
      end
    end
  end

  assign stat_o.bad_den  = (ad_q == '0) || (bd_q == '0);
  assign stat_o.div_zero = (op_q == OP_DIV) && (bn_q == '0);
  assign stat_o.num_zero = (nm_q == '0);
  assign stat_o.gcd_done = (x_q == '0) || (y_q == '0);
  assign stat_o.div_done = (cnt_q == '0);

  assign res_num_o = rnum_q;
  assign res_den_o = rden_q;
  assign status_o  = rst_q;

endmodule

// ===== rtl/rau_ctrl.sv =====
// rational arithmetic unit controller: sequences one request at a time
// depends on rau_pkg
module rau_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  rau_pkg::rau_stat_t stat_i,
  output rau_pkg::rau_cmd_t  cmd_o
);
  import rau_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PROD = 3'd1;
  localparam logic [2:0] S_COMB = 3'd2;
  localparam logic [2:0] S_GCD  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state_q, state_d;
  logic [1:0] pi_q, pi_d;
  logic       ov_q, ov_d;

  // one request in flight; a waiting result only holds back the finish step
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ov_q;

  always_comb begin
    state_d = state_q;
    pi_d    = pi_q;
    ov_d    = ov_q && !out_ready_i;
    cmd_o   = '0;
    cmd_o.prod_sel = pi_q;
    case (state_q)
      S_IDLE: if (in_valid_i && in_ready_o) begin
        cmd_o.load = 1'b1; state_d = S_PROD; pi_d = '0;
      end
      S_PROD: begin
        if (stat_i.bad_den || stat_i.div_zero) begin
          state_d = S_FIN;
        end else begin
          cmd_o.prod = 1'b1; pi_d = pi_q + 1'b1;
          if (pi_q == 2'd3) state_d = S_COMB;
        end
      end
      S_COMB: begin cmd_o.combine = 1'b1; state_d = S_GCD; end
      S_GCD: begin
        if (stat_i.num_zero) state_d = S_FIN;
        else if (stat_i.gcd_done) begin cmd_o.div_start = 1'b1; state_d = S_DIV; end
        else cmd_o.gcd_step = 1'b1;
      end
      S_DIV: begin
        if (stat_i.div_done) state_d = S_FIN;
        else cmd_o.div_step = 1'b1;
      end
      S_FIN: if (!ov_q || out_ready_i) begin
        cmd_o.finish = 1'b1; ov_d = 1'b1; state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; pi_q <= '0; ov_q <= 1'b0;
    end else begin
      state_q <= state_d; pi_q <= pi_d; ov_q <= ov_d;
    end
  end

endmodule

// ===== rtl/rational_arithmetic_unit_top.sv =====
// rational arithmetic unit top level: controller plus datapath
// depends on rau_pkg, rau_ctrl, rau_datapath
//
// Usage: one request beat on in_valid_i/in_ready_o carries an operation
// and two fractions; one result beat on out_valid_o/out_ready_i returns
// the reduced fraction and a status. One request is worked at a time.
// A request runs through the product steps, the combine step, the binary
// gcd steps and the bit-serial reducing divisions of both values; most
// of the run time goes to the gcd loop and the serial divider.
// Error cases (zero denominator, divide by zero) skip to the result.
// The result sits in an output register; a new request is taken while it
// waits, and the next result waits until it is taken. Reset clears the
// controller and drops out_valid_o.
module rational_arithmetic_unit_top #(
  parameter int WORD_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         req_type_i,
  input  logic signed [31:0] a_num_i,
  input  logic [30:0]        a_den_i,
  input  logic signed [31:0] b_num_i,
  input  logic [30:0]        b_den_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] res_num_o,
  output logic [30:0]        res_den_o,
  output logic [1:0]         status_o
);
  import rau_pkg::*;

  rau_cmd_t  cmd;
  rau_stat_t stat;

  rau_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .stat_i(stat), .cmd_o(cmd)
  );

  rau_datapath #(.WORD_BITS(WORD_BITS)) u_dp (
    .clk_i, .req_type_i, .a_num_i, .a_den_i, .b_num_i, .b_den_i,
    .cmd_i(cmd), .stat_o(stat), .res_num_o, .res_den_o, .status_o
  );

endmodule
